>>> hdl/nearest_neighbor_pixel_scaler_macros.svh
// Assertion helpers for the scaler checker.
`ifndef NEAREST_NEIGHBOR_PIXEL_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_PIXEL_SCALER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define NNPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NNPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/nnps_pkg.sv
package nnps_pkg;

  // Register and field widths
  localparam int REG_W       = 13;
  localparam int REG_MAX     = (1 << REG_W) - 1;
  localparam int CFG_IDX_W   = 3;
  localparam int PIX_FIELD_W = 24;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_REPEAT = 64;
  localparam int DEF_PIXEL_BITS = 24;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_DEST_WIDTH    = 3'd1,
    REG_SOURCE_HEIGHT = 3'd2,
    REG_DEST_HEIGHT   = 3'd3
  } cfg_reg_t;

  // Per-run flags carried with each queue entry
  typedef struct packed {
    logic line_end;
    logic overflow;
  } nnps_flags_t;

  // Zero reads as one, anything above the limit reads as the limit
  function automatic logic [REG_W-1:0] clamp_size(input logic [REG_W-1:0] v,
                                                  input logic [REG_W-1:0] lim);
    logic [REG_W-1:0] r;
    if (v == '0) begin
      r = REG_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> hdl/nearest_neighbor_pixel_scaler.sv
// Channel   Direction  Handshake            Payload
// src       in         src_valid/src_stall  pixel_value, frame_start
// dst       out        dst_valid/dst_stall  out_pixel, run_last, line_end, repeat_overflow
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A dropped pixel, or a pixel repeated while the column error is below source_width,
// stays in F_IDLE; a kept pixel when shrinking also passes F_LEND (line end check).
// A repeat run with column error at or above source_width goes through F_DIV, then F_FIN;
// F_DIV is the one-bit-a-cycle quotient loop.
// The back sends one result per cycle, unless dst_stall holds it, from a 2-entry queue.
// Synchronous active-high reset; no clearing pass. The sides stall independently.
module nearest_neighbor_pixel_scaler
  import nnps_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_REPEAT = DEF_MAX_REPEAT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // source pixels
  input  logic                   src_valid,
  output logic                   src_stall,
  input  logic [PIX_FIELD_W-1:0] pixel_value,
  input  logic                   frame_start,
  // destination pixels
  output logic                   dst_valid,
  input  logic                   dst_stall,
  output logic [PIX_FIELD_W-1:0] out_pixel,
  output logic                   run_last,
  output logic                   line_end,
  output logic                   repeat_overflow,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  localparam int REP_W = $clog2(MAX_REPEAT + 1);

  logic                  push_valid;
  logic [PIXEL_BITS-1:0] push_pixel;
  logic [REP_W-1:0]      push_count;
  nnps_flags_t           push_flags;
  logic [PIXEL_BITS-1:0] head_pixel;
  logic [REP_W-1:0]      head_count;
  nnps_flags_t           head_flags;
  logic                  not_empty;
  logic                  q_space;
  logic                  pop;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  nnps_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_REPEAT (MAX_REPEAT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .pixel_value (pixel_value),
    .frame_start (frame_start),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_space     (q_space),
    .push_valid  (push_valid),
    .push_pixel  (push_pixel),
    .push_count  (push_count),
    .push_flags  (push_flags)
  );

  nnps_queue #(
    .MAX_REPEAT (MAX_REPEAT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push_valid),
    .push_pixel (push_pixel),
    .push_count (push_count),
    .push_flags (push_flags),
    .pop        (pop),
    .head_pixel (head_pixel),
    .head_count (head_count),
    .head_flags (head_flags),
    .not_empty  (not_empty),
    .space      (q_space)
  );

  nnps_back #(
    .MAX_REPEAT (MAX_REPEAT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head_pixel      (head_pixel),
    .head_count      (head_count),
    .head_flags      (head_flags),
    .not_empty       (not_empty),
    .pop             (pop),
    .dst_valid       (dst_valid),
    .dst_stall       (dst_stall),
    .out_pixel       (out_pixel),
    .run_last        (run_last),
    .line_end        (line_end),
    .repeat_overflow (repeat_overflow)
  );

endmodule

>>> hdl/nnps_queue.sv
module nnps_queue
  import nnps_pkg::*;
#(
  parameter int MAX_REPEAT = DEF_MAX_REPEAT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic [PIXEL_BITS-1:0]              push_pixel,
  input  logic [$clog2(MAX_REPEAT+1)-1:0]    push_count,
  input  nnps_flags_t                        push_flags,
  input  logic                               pop,
  output logic [PIXEL_BITS-1:0]              head_pixel,
  output logic [$clog2(MAX_REPEAT+1)-1:0]    head_count,
  output nnps_flags_t                        head_flags,
  output logic                               not_empty,
  output logic                               space
);

  localparam int REP_W  = $clog2(MAX_REPEAT + 1);
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [PIXEL_BITS-1:0] pix_mem  [QUEUE_DEPTH];
  logic [REP_W-1:0]      cnt_mem  [QUEUE_DEPTH];
  nnps_flags_t           flag_mem [QUEUE_DEPTH];

  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      pix_mem[wr_ptr]  <= push_pixel;
      cnt_mem[wr_ptr]  <= push_count;
      flag_mem[wr_ptr] <= push_flags;
    end
  end

  assign head_pixel = pix_mem[rd_ptr];
  assign head_count = cnt_mem[rd_ptr];
  assign head_flags = flag_mem[rd_ptr];
  assign not_empty  = (fill != '0);
  assign space      = (fill != FILL_W'(QUEUE_DEPTH));

endmodule

>>> hdl/nnps_front.sv
module nnps_front
  import nnps_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_REPEAT = DEF_MAX_REPEAT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // source pixels
  input  logic                               src_valid,
  output logic                               src_stall,
  input  logic [PIX_FIELD_W-1:0]             pixel_value,
  input  logic                               frame_start,
  // register writes
  input  logic                               cfg_wr,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [REG_W-1:0]                   cfg_data,
  // queue side
  input  logic                               q_space,
  output logic                               push_valid,
  output logic [PIXEL_BITS-1:0]              push_pixel,
  output logic [$clog2(MAX_REPEAT+1)-1:0]    push_count,
  output nnps_flags_t                        push_flags
);

  localparam int SIZE_MAX = (MAX_WIDTH < REG_MAX) ? MAX_WIDTH : REG_MAX;
  localparam int SZ_W     = $clog2(SIZE_MAX + 1);
  localparam int CNT_W    = $clog2(SIZE_MAX);
  localparam int ACC_W    = SZ_W + 1;
  localparam int PROD_W   = 2 * ACC_W;
  localparam int REP_W    = $clog2(MAX_REPEAT + 1);
  localparam int DCNT_W   = $clog2(SZ_W);
  localparam logic [REG_W-1:0] SIZE_LIM = REG_W'(SIZE_MAX);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_LEND = 4'b0010,
    F_DIV  = 4'b0100,
    F_FIN  = 4'b1000
  } front_state_t;

  front_state_t state;

  // Configuration registers
  logic [REG_W-1:0] source_width;
  logic [REG_W-1:0] dest_width;
  logic [REG_W-1:0] source_height;
  logic [REG_W-1:0] dest_height;

  // Scan state
  logic signed [ACC_W-1:0] row_acc;
  logic signed [ACC_W-1:0] col_acc;
  logic [CNT_W-1:0]        col_count;
  logic                    line_kept;

  // Held item while a shrink line end check or a quotient runs
  logic [PIXEL_BITS-1:0]    pix_r;
  logic                     kept_r;
  logic                     last_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;

  // Quotient unit, one bit a cycle
  logic [SZ_W-1:0]   div_num;
  logic [SZ_W-1:0]   div_rem;
  logic [SZ_W-1:0]   div_quo;
  logic [DCNT_W-1:0] div_cnt;

  logic [SZ_W-1:0] sw, dw, sh, dh;
  logic signed [ACC_W-1:0] sws, dws, shs, dhs, wdiff, hdiff, wabs;
  logic shrink_w, shrink_h, accept;

  logic signed [ACC_W-1:0]  row_eff, row_nx, cacc_eff, cacc_nx, span_diff;
  logic [CNT_W-1:0]         cc_eff, cc_nx;
  logic [SZ_W-1:0]          pos;
  logic                     kept, last_col, emit, need_div;
  logic signed [PROD_W-1:0] prod;

  logic [SZ_W:0]            trial;
  logic                     ge;
  logic [SZ_W-1:0]          rem_step;
  logic signed [ACC_W-1:0]  fin_acc;
  logic                     fin_ovf;
  logic [REP_W-1:0]         fin_count;
  logic                     lend_hit;

  // Effective sizes
  assign sw  = SZ_W'(clamp_size(source_width, SIZE_LIM));
  assign dw  = SZ_W'(clamp_size(dest_width, SIZE_LIM));
  assign sh  = SZ_W'(clamp_size(source_height, SIZE_LIM));
  assign dh  = SZ_W'(clamp_size(dest_height, SIZE_LIM));
  assign sws = $signed({1'b0, sw});
  assign dws = $signed({1'b0, dw});
  assign shs = $signed({1'b0, sh});
  assign dhs = $signed({1'b0, dh});

  assign shrink_w = (sw >= dw);
  assign shrink_h = (sh > dh);
  assign wdiff    = sws - dws;
  assign hdiff    = shs - dhs;
  assign wabs     = shrink_w ? wdiff : (dws - sws);

  assign src_stall = !((state == F_IDLE) && q_space);
  assign accept    = src_valid && !src_stall;

  // Line and frame bookkeeping for the incoming pixel
  always_comb begin
    row_eff = frame_start ? (shrink_h ? hdiff : '0) : row_acc;
    cc_eff  = frame_start ? '0 : col_count;
    if (cc_eff == '0) begin
      cacc_eff = wabs;
      if (shrink_h && (row_eff > 0)) begin
        kept   = 1'b0;
        row_nx = row_eff - dhs;
      end else if (shrink_h) begin
        kept   = 1'b1;
        row_nx = row_eff + hdiff;
      end else begin
        kept   = 1'b1;
        row_nx = row_eff;
      end
    end else begin
      cacc_eff = col_acc;
      kept     = line_kept;
      row_nx   = row_eff;
    end
    pos       = SZ_W'(cc_eff) + SZ_W'(1);
    last_col  = (pos >= sw);
    cc_nx     = last_col ? '0 : CNT_W'(pos);
    span_diff = sws - $signed({1'b0, pos});
  end

  // Horizontal decision: drop, keep once, repeat, or repeat past the divisor
  always_comb begin
    emit     = 1'b0;
    need_div = 1'b0;
    if (shrink_w) begin
      if (cacc_eff > 0) begin
        cacc_nx = cacc_eff - dws;
      end else begin
        cacc_nx = cacc_eff + wdiff;
        emit    = 1'b1;
      end
    end else if (cacc_eff < 0) begin
      cacc_nx = cacc_eff + dws;
    end else if (cacc_eff < sws) begin
      cacc_nx = cacc_eff - sws + dws;
      emit    = 1'b1;
    end else begin
      cacc_nx  = cacc_eff;
      need_div = 1'b1;
    end
  end

  // Distance to line end, checked against the accumulator in the cycle after
  assign prod     = PROD_W'(dws) * PROD_W'(span_diff);
  assign lend_hit = (PROD_W'(acc_r) == (PROD_W'(wdiff) + prod_r));

  // Quotient step and run length
  assign trial     = {div_rem, div_num[SZ_W-1]};
  assign ge        = (trial >= {1'b0, sw});
  assign rem_step  = ge ? SZ_W'(trial - {1'b0, sw}) : SZ_W'(trial);
  assign fin_acc   = $signed({1'b0, div_rem}) - sws + dws;
  assign fin_ovf   = (32'(div_quo) >= MAX_REPEAT);
  assign fin_count = fin_ovf ? REP_W'(MAX_REPEAT) : (REP_W'(div_quo) + REP_W'(1));

  // Queue push
  always_comb begin
    push_valid          = 1'b0;
    push_pixel          = pix_r;
    push_count          = REP_W'(1);
    push_flags.line_end = 1'b0;
    push_flags.overflow = 1'b0;
    unique case (state)
      F_IDLE: begin
        push_valid          = accept && !shrink_w && emit && kept;
        push_pixel          = pixel_value[PIXEL_BITS-1:0];
        push_flags.line_end = last_col;
      end
      F_LEND: begin
        push_valid          = 1'b1;
        push_flags.line_end = lend_hit;
      end
      F_DIV: begin
        push_valid = 1'b0;
      end
      F_FIN: begin
        push_valid          = kept_r;
        push_count          = fin_count;
        push_flags.line_end = last_r;
        push_flags.overflow = fin_ovf;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  // Control state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      source_width  <= REG_W'(1);
      dest_width    <= REG_W'(1);
      source_height <= REG_W'(1);
      dest_height   <= REG_W'(1);
      row_acc       <= '0;
      col_acc       <= '0;
      col_count     <= '0;
      line_kept     <= 1'b1;
      div_cnt       <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_SOURCE_WIDTH:  source_width  <= cfg_data;
          REG_DEST_WIDTH:    dest_width    <= cfg_data;
          REG_SOURCE_HEIGHT: source_height <= cfg_data;
          REG_DEST_HEIGHT:   dest_height   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            row_acc   <= row_nx;
            line_kept <= kept;
            col_count <= cc_nx;
            div_cnt   <= '0;
            if (!need_div) begin
              col_acc <= cacc_nx;
            end
            if (need_div) begin
              state <= F_DIV;
            end else if (shrink_w && emit && kept) begin
              state <= F_LEND;
            end
          end
        end
        F_LEND: begin
          state <= F_IDLE;
        end
        F_DIV: begin
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DCNT_W'(SZ_W - 1)) begin
            state <= F_FIN;
          end
        end
        F_FIN: begin
          col_acc <= fin_acc;
          state   <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // Held item and quotient datapath
  always_ff @(posedge clk) begin
    if (state == F_IDLE && accept) begin
      pix_r   <= pixel_value[PIXEL_BITS-1:0];
      kept_r  <= kept;
      last_r  <= last_col;
      acc_r   <= cacc_nx;
      prod_r  <= prod;
      div_num <= cacc_eff[SZ_W-1:0];
      div_rem <= '0;
      div_quo <= '0;
    end else if (state == F_DIV) begin
      div_num <= div_num << 1;
      div_rem <= rem_step;
      div_quo <= {div_quo[SZ_W-2:0], ge};
    end
  end

endmodule

>>> hdl/nnps_back.sv
module nnps_back
  import nnps_pkg::*;
#(
  parameter int MAX_REPEAT = DEF_MAX_REPEAT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // queue side
  input  logic [PIXEL_BITS-1:0]              head_pixel,
  input  logic [$clog2(MAX_REPEAT+1)-1:0]    head_count,
  input  nnps_flags_t                        head_flags,
  input  logic                               not_empty,
  output logic                               pop,
  // destination pixels
  output logic                               dst_valid,
  input  logic                               dst_stall,
  output logic [PIX_FIELD_W-1:0]             out_pixel,
  output logic                               run_last,
  output logic                               line_end,
  output logic                               repeat_overflow
);

  localparam int REP_W = $clog2(MAX_REPEAT + 1);

  logic [REP_W-1:0] rep_idx;
  logic             load;
  logic             last;

  // Output register is free when empty or being taken this cycle
  assign load = not_empty && (!dst_valid || !dst_stall);
  assign last = ((rep_idx + REP_W'(1)) == head_count);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
      rep_idx   <= '0;
    end else begin
      if (load) begin
        dst_valid <= 1'b1;
        rep_idx   <= last ? '0 : (rep_idx + REP_W'(1));
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_pixel       <= PIX_FIELD_W'(head_pixel);
      run_last        <= last;
      line_end        <= last && head_flags.line_end;
      repeat_overflow <= head_flags.overflow;
    end
  end

endmodule

>>> hdl/nnps_checker.sv
`include "nearest_neighbor_pixel_scaler_macros.svh"

module nnps_checker
  import nnps_pkg::*;
#(
  parameter int MAX_REPEAT = DEF_MAX_REPEAT
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   dst_valid,
  input logic                   dst_stall,
  input logic [PIX_FIELD_W-1:0] out_pixel,
  input logic                   run_last,
  input logic                   line_end,
  input logic                   repeat_overflow
);

  localparam int REP_W = $clog2(MAX_REPEAT + 1);
  localparam logic [REP_W-1:0] REP_LIM = REP_W'(MAX_REPEAT);
  localparam logic [REP_W-1:0] REP_END = REP_W'(MAX_REPEAT - 1);

  logic                   take;
  logic [REP_W-1:0]       run_len;
  logic [PIX_FIELD_W-1:0] run_pixel;
  logic                   run_ovf;
  logic                   hold_req;
  logic                   in_run;
  logic                   run_match;
  logic                   ovf_last;
  logic [PIX_FIELD_W+2:0] dst_word;

  assign take = dst_valid && !dst_stall;

  // Terms used by the checks below
  assign hold_req  = dst_valid && dst_stall;
  assign in_run    = dst_valid && (run_len != '0);
  assign run_match = (out_pixel == run_pixel) && (repeat_overflow == run_ovf);
  assign ovf_last  = dst_valid && repeat_overflow && run_last;
  assign dst_word  = {out_pixel, run_last, line_end, repeat_overflow};

  // Results already taken in the current run
  always_ff @(posedge clk) begin
    if (rst) begin
      run_len <= '0;
    end else if (take) begin
      run_len <= run_last ? '0 : (run_len + REP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      run_pixel <= out_pixel;
      run_ovf   <= repeat_overflow;
    end
  end

  `NNPS_ASSERT_NEXT(a_dst_hold, clk, rst, hold_req, dst_valid && $stable(dst_word), "stall broke hold")
  `NNPS_ASSERT_NOW(a_run_limit, clk, rst, dst_valid, run_len < REP_LIM, "run over repeat limit")
  `NNPS_ASSERT_NOW(a_run_same, clk, rst, in_run, run_match, "run changed pixel or overflow")
  `NNPS_ASSERT_NOW(a_ovf_full, clk, rst, ovf_last, run_len == REP_END, "clipped run too short")

endmodule

bind nearest_neighbor_pixel_scaler nnps_checker #(.MAX_REPEAT(MAX_REPEAT)) u_nnps_checker (.*);
